// ===== rtl/lbrl_pkg.sv =====
// Shared widths, register indexes and controller/datapath interface types.
package lbrl_pkg;

   localparam int NOW_W       = 32;
   localparam int SIZE_W      = 31;
   localparam int INTERVAL_W  = 31;
   localparam int LIMIT_W     = 40;
   localparam int RATE_W      = 40;
   localparam int LEVEL_W     = 48;
   localparam int WAIT_W      = 32;
   localparam int HALF_W      = RATE_W / 2;
   localparam int PP_W        = NOW_W + HALF_W;
   localparam int PROD_W      = NOW_W + RATE_W;
   localparam int DIV_STEPS   = LEVEL_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 40;

   localparam logic [CSR_INDEX_W-1:0] REG_INTERVAL = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT    = CSR_INDEX_W'(1);

   localparam logic [WAIT_W-1:0]  WAIT_MAX  = {WAIT_W{1'b1}};
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

   typedef struct packed {
      logic cfg_write;
      logic take_req;
      logic rate_clear;
      logic rate_load;
      logic div_start;
      logic div_for_wait;
      logic mul_lo;
      logic mul_hi;
      logic drain;
      logic mark_set;
      logic res_clear;
      logic res_max;
      logic res_wait;
      logic fill_add;
      logic rsp_load;
   } lbrl_cmd_type;

   typedef struct packed {
      logic cfg_known;
      logic interval_zero;
      logic trivial;
      logic due;
      logic rate_zero;
      logic over_limit;
      logic div_done;
   } lbrl_status_type;

endpackage

// ===== rtl/lbrl_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module lbrl_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lbrl_pkg::LEVEL_W-1:0]      dividend,
   input  logic [lbrl_pkg::RATE_W-1:0]       divisor,
   output logic [lbrl_pkg::LEVEL_W-1:0]      quotient,
   output logic                              done
);

   logic [lbrl_pkg::RATE_W-1:0]    rem_ff, rem_in;
   logic [lbrl_pkg::LEVEL_W-1:0]   quo_ff, quo_in;
   logic [lbrl_pkg::RATE_W-1:0]    divisor_ff, divisor_in;
   logic [lbrl_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [lbrl_pkg::RATE_W:0]      rem_shift;
   logic [lbrl_pkg::RATE_W:0]      rem_diff;
   logic                           fits;

   assign rem_shift = {rem_ff, quo_ff[lbrl_pkg::LEVEL_W-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign fits      = rem_shift >= {1'b0, divisor_ff};

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
         count_in   = lbrl_pkg::DIV_CNT_W'(lbrl_pkg::DIV_STEPS);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? rem_diff[lbrl_pkg::RATE_W-1:0] : rem_shift[lbrl_pkg::RATE_W-1:0];
         quo_in   = {quo_ff[lbrl_pkg::LEVEL_W-2:0], fits};
         count_in = count_ff - lbrl_pkg::DIV_CNT_W'(1);
         if (count_ff == lbrl_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/lbrl_datapath.sv =====
// Bucket state, drain multiplier, comparisons, divider and result register.
module lbrl_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  lbrl_pkg::lbrl_cmd_type              cmd,
   output lbrl_pkg::lbrl_status_type           status,
   input  logic [lbrl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lbrl_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic [lbrl_pkg::NOW_W-1:0]          req_now_ms,
   input  logic [lbrl_pkg::SIZE_W-1:0]         req_size,
   output logic [lbrl_pkg::WAIT_W-1:0]         rsp_wait_ms,
   output logic                                rsp_delayed
);

   logic [lbrl_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic [lbrl_pkg::LIMIT_W-1:0]    limit_ff, limit_in;
   logic [lbrl_pkg::RATE_W-1:0]     rate_ff, rate_in;
   logic [lbrl_pkg::LEVEL_W-1:0]    fill_ff, fill_in;
   logic [lbrl_pkg::NOW_W-1:0]      mark_ff, mark_in;
   logic [lbrl_pkg::NOW_W-1:0]      now_ff, now_in;
   logic [lbrl_pkg::SIZE_W-1:0]     size_ff, size_in;
   logic [lbrl_pkg::PROD_W-1:0]     acc_ff, acc_in;
   logic [lbrl_pkg::WAIT_W-1:0]     res_wait_ff, res_wait_in;
   logic                            res_delayed_ff, res_delayed_in;
   logic [lbrl_pkg::WAIT_W-1:0]     rsp_wait_ff, rsp_wait_in;
   logic                            rsp_delayed_ff, rsp_delayed_in;

   logic [lbrl_pkg::NOW_W-1:0]      elapsed;
   logic [lbrl_pkg::HALF_W-1:0]     mul_half;
   logic [lbrl_pkg::PP_W-1:0]       pp;
   logic                            drain_all;
   logic [lbrl_pkg::LEVEL_W-1:0]    excess;
   logic [lbrl_pkg::LEVEL_W:0]      fill_sum;
   logic [lbrl_pkg::LEVEL_W-1:0]    div_dividend;
   logic [lbrl_pkg::RATE_W-1:0]     div_divisor;
   logic [lbrl_pkg::LEVEL_W-1:0]    div_quotient;
   logic                            div_done;

   assign elapsed   = now_ff - mark_ff;
   assign mul_half  = cmd.mul_hi ? rate_ff[lbrl_pkg::RATE_W-1:lbrl_pkg::HALF_W]
                                 : rate_ff[lbrl_pkg::HALF_W-1:0];
   assign pp        = lbrl_pkg::PP_W'(elapsed) * lbrl_pkg::PP_W'(mul_half);
   assign drain_all = acc_ff >= {{(lbrl_pkg::PROD_W-lbrl_pkg::LEVEL_W){1'b0}}, fill_ff};
   assign excess    = fill_ff - {{(lbrl_pkg::LEVEL_W-lbrl_pkg::LIMIT_W){1'b0}}, limit_ff};
   assign fill_sum  = {1'b0, fill_ff}
                    + {{(lbrl_pkg::LEVEL_W+1-lbrl_pkg::SIZE_W){1'b0}}, size_ff};

   assign div_dividend = cmd.div_for_wait ? excess
                       : {{(lbrl_pkg::LEVEL_W-lbrl_pkg::LIMIT_W){1'b0}}, limit_ff};
   assign div_divisor  = cmd.div_for_wait ? rate_ff
                       : {{(lbrl_pkg::RATE_W-lbrl_pkg::INTERVAL_W){1'b0}}, interval_ff};

   lbrl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   always_comb begin
      status.cfg_known     = (csr_index == lbrl_pkg::REG_INTERVAL)
                          || (csr_index == lbrl_pkg::REG_LIMIT);
      status.interval_zero = interval_ff == '0;
      status.trivial       = (size_ff == '0) || (interval_ff == '0);
      status.due           = elapsed >= {1'b0, interval_ff};
      status.rate_zero     = rate_ff == '0;
      status.over_limit    = fill_ff > {{(lbrl_pkg::LEVEL_W-lbrl_pkg::LIMIT_W){1'b0}}, limit_ff};
      status.div_done      = div_done;
   end

   always_comb begin
      interval_in    = interval_ff;
      limit_in       = limit_ff;
      rate_in        = rate_ff;
      fill_in        = fill_ff;
      mark_in        = mark_ff;
      now_in         = now_ff;
      size_in        = size_ff;
      acc_in         = acc_ff;
      res_wait_in    = res_wait_ff;
      res_delayed_in = res_delayed_ff;
      rsp_wait_in    = rsp_wait_ff;
      rsp_delayed_in = rsp_delayed_ff;

      if (cmd.cfg_write) begin
         if (csr_index == lbrl_pkg::REG_INTERVAL) begin
            interval_in = csr_data[lbrl_pkg::INTERVAL_W-1:0];
         end else begin
            limit_in = csr_data[lbrl_pkg::LIMIT_W-1:0];
         end
      end

      priority if (cmd.rate_clear) begin
         rate_in = '0;
      end else if (cmd.rate_load) begin
         rate_in = div_quotient[lbrl_pkg::RATE_W-1:0];
      end else begin
         rate_in = rate_ff;
      end

      if (cmd.take_req) begin
         now_in  = req_now_ms;
         size_in = req_size;
      end

      priority if (cmd.mul_lo) begin
         acc_in = {{lbrl_pkg::HALF_W{1'b0}}, pp};
      end else if (cmd.mul_hi) begin
         acc_in = acc_ff + {pp, {lbrl_pkg::HALF_W{1'b0}}};
      end else begin
         acc_in = acc_ff;
      end

      priority if (cmd.cfg_write) begin
         fill_in = '0;
      end else if (cmd.drain) begin
         fill_in = drain_all ? '0 : (fill_ff - acc_ff[lbrl_pkg::LEVEL_W-1:0]);
      end else if (cmd.fill_add) begin
         fill_in = fill_sum[lbrl_pkg::LEVEL_W] ? lbrl_pkg::LEVEL_MAX
                                               : fill_sum[lbrl_pkg::LEVEL_W-1:0];
      end else begin
         fill_in = fill_ff;
      end

      priority if (cmd.cfg_write) begin
         mark_in = '0;
      end else if (cmd.mark_set) begin
         mark_in = now_ff;
      end else begin
         mark_in = mark_ff;
      end

      priority if (cmd.res_clear) begin
         res_wait_in    = '0;
         res_delayed_in = 1'b0;
      end else if (cmd.res_max) begin
         res_wait_in    = lbrl_pkg::WAIT_MAX;
         res_delayed_in = 1'b1;
      end else if (cmd.res_wait) begin
         res_wait_in    = (div_quotient[lbrl_pkg::LEVEL_W-1:lbrl_pkg::WAIT_W] != '0)
                        ? lbrl_pkg::WAIT_MAX : div_quotient[lbrl_pkg::WAIT_W-1:0];
         res_delayed_in = 1'b1;
      end else begin
         res_wait_in    = res_wait_ff;
         res_delayed_in = res_delayed_ff;
      end

      if (cmd.rsp_load) begin
         rsp_wait_in    = res_wait_ff;
         rsp_delayed_in = res_delayed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
         limit_ff    <= '0;
         rate_ff     <= '0;
         fill_ff     <= '0;
         mark_ff     <= '0;
      end else begin
         interval_ff <= interval_in;
         limit_ff    <= limit_in;
         rate_ff     <= rate_in;
         fill_ff     <= fill_in;
         mark_ff     <= mark_in;
      end
      now_ff         <= now_in;
      size_ff        <= size_in;
      acc_ff         <= acc_in;
      res_wait_ff    <= res_wait_in;
      res_delayed_ff <= res_delayed_in;
      rsp_wait_ff    <= rsp_wait_in;
      rsp_delayed_ff <= rsp_delayed_in;
   end

   assign rsp_wait_ms = rsp_wait_ff;
   assign rsp_delayed = rsp_delayed_ff;

endmodule

// ===== rtl/lbrl_ctrl.sv =====
// Sequencing state machine for configuration, drain, wait division and result beats.
module lbrl_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  lbrl_pkg::lbrl_status_type status,
   output lbrl_pkg::lbrl_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_RATE      = 4'd1;
   localparam logic [3:0] ST_RATE_WAIT = 4'd2;
   localparam logic [3:0] ST_CHECK     = 4'd3;
   localparam logic [3:0] ST_MUL_LO    = 4'd4;
   localparam logic [3:0] ST_MUL_HI    = 4'd5;
   localparam logic [3:0] ST_DRAIN     = 4'd6;
   localparam logic [3:0] ST_LEVEL     = 4'd7;
   localparam logic [3:0] ST_WAIT_DIV  = 4'd8;
   localparam logic [3:0] ST_ADD       = 4'd9;
   localparam logic [3:0] ST_OUT       = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign csr_ready = state_ff == ST_IDLE;
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               if (status.cfg_known) begin
                  cmd.cfg_write = 1'b1;
                  state_in      = ST_RATE;
               end
            end else if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_RATE: begin
            if (status.interval_zero) begin
               cmd.rate_clear = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_RATE_WAIT;
            end
         end
         ST_RATE_WAIT: begin
            if (status.div_done) begin
               cmd.rate_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_CHECK: begin
            priority if (status.trivial) begin
               cmd.res_clear = 1'b1;
               state_in      = ST_OUT;
            end else if (status.due && !status.rate_zero) begin
               state_in = ST_MUL_LO;
            end else if (status.due) begin
               cmd.mark_set = 1'b1;
               state_in     = ST_LEVEL;
            end else begin
               state_in = ST_LEVEL;
            end
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_DRAIN;
         end
         ST_DRAIN: begin
            cmd.drain    = 1'b1;
            cmd.mark_set = 1'b1;
            state_in     = ST_LEVEL;
         end
         ST_LEVEL: begin
            priority if (!status.over_limit) begin
               cmd.res_clear = 1'b1;
               state_in      = ST_ADD;
            end else if (status.rate_zero) begin
               cmd.res_max = 1'b1;
               state_in    = ST_ADD;
            end else begin
               cmd.div_start    = 1'b1;
               cmd.div_for_wait = 1'b1;
               state_in         = ST_WAIT_DIV;
            end
         end
         ST_WAIT_DIV: begin
            cmd.div_for_wait = 1'b1;
            if (status.div_done) begin
               cmd.res_wait = 1'b1;
               state_in     = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.fill_add = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/leaky_bucket_rate_limiter.sv =====
// Top level of the leaky-bucket rate limiter: controller, datapath and checks.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid/req_ready    req_now_ms[31:0], req_size[30:0]
//   rsp       out        rsp_valid/rsp_ready    rsp_wait_ms[31:0], rsp_delayed
//   csr       in         csr_valid/csr_ready    csr_index[7:0], csr_data[39:0]
//
// A request beat skips the drain and the division when the size or interval is zero,
// skips the division when no wait is needed, and runs the 48-step radix-2 divider
// when a wait is computed. A write to the interval or limit register recomputes the
// drain rate on that divider (or clears it at zero interval) with req_ready held low.
// Reset is synchronous and clears the bucket and the registers.
// A stalled result sits in the output register while the next request beat is accepted.
module leaky_bucket_rate_limiter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lbrl_pkg::NOW_W-1:0]          req_now_ms,
   input  logic [lbrl_pkg::SIZE_W-1:0]         req_size,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lbrl_pkg::WAIT_W-1:0]         rsp_wait_ms,
   output logic                                rsp_delayed,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lbrl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lbrl_pkg::CSR_DATA_W-1:0]     csr_data
);

   lbrl_pkg::lbrl_cmd_type    cmd;
   lbrl_pkg::lbrl_status_type status;

   lbrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lbrl_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_now_ms  (req_now_ms),
      .req_size    (req_size),
      .rsp_wait_ms (rsp_wait_ms),
      .rsp_delayed (rsp_delayed)
   );

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while the previous one is still in work");

   a_busy_after_cfg: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready
         && (csr_index == lbrl_pkg::REG_INTERVAL || csr_index == lbrl_pkg::REG_LIMIT)
      |=> !req_ready)
      else $error("request admitted before the drain rate was recomputed");

   a_wait_needs_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_delayed |-> rsp_wait_ms == '0)
      else $error("nonzero wait on a result that was not delayed");

endmodule

// ===== tb/tb_leaky_bucket_rate_limiter.sv =====
// Self-checking testbench for the leaky-bucket rate limiter with a built-in bucket predictor.
`timescale 1ns / 1ps

module tb_leaky_bucket_rate_limiter;

   localparam int RANDOM_ITEMS = 1330;
   localparam int STALL_LIMIT  = 2000;
   localparam int DIRECTED_ROWS = 25;
   localparam logic [lbrl_pkg::CSR_INDEX_W-1:0] REG_SPARE = lbrl_pkg::CSR_INDEX_W'(200);

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;

   typedef struct packed {
      row_kind_type                         kind;
      logic [lbrl_pkg::CSR_INDEX_W-1:0]     index;
      logic [lbrl_pkg::CSR_DATA_W-1:0]      data;
      logic [lbrl_pkg::NOW_W-1:0]           now_ms;
      logic [lbrl_pkg::SIZE_W-1:0]          size;
      logic                                 typed;
      logic [lbrl_pkg::WAIT_W-1:0]          wait_ms;
      logic                                 delayed;
   } plan_row_type;

   typedef struct packed {
      logic [lbrl_pkg::WAIT_W-1:0] wait_ms;
      logic                        delayed;
   } grant_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [lbrl_pkg::NOW_W-1:0]       req_now_ms = '0;
   logic [lbrl_pkg::SIZE_W-1:0]      req_size = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [lbrl_pkg::WAIT_W-1:0]      rsp_wait_ms;
   logic                             rsp_delayed;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [lbrl_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lbrl_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   logic [lbrl_pkg::INTERVAL_W-1:0]  interval_cfg = '0;
   logic [lbrl_pkg::LIMIT_W-1:0]     limit_cfg = '0;
   logic [lbrl_pkg::RATE_W-1:0]      drain_rate = '0;
   logic [lbrl_pkg::LEVEL_W-1:0]     bucket_level = '0;
   logic [lbrl_pkg::NOW_W-1:0]       drain_mark_ms = '0;

   grant_type expected_grants[$];
   int        mismatch_count = 0;
   int        idle_cycles = 0;
   int        req_gap_pct = 6;
   int        rsp_gap_pct = 45;

   plan_row_type directed_plan [DIRECTED_ROWS] = '{
      '{ROW_REQ, '0, '0, 32'd5, 31'd100, 1'b1, 32'd0, 1'b0},
      '{ROW_CSR, lbrl_pkg::REG_INTERVAL, 40'd1000, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_CSR, lbrl_pkg::REG_LIMIT, 40'd0, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_REQ, '0, '0, 32'd0, 31'h7FFF_FFFF, 1'b1, 32'd0, 1'b0},
      '{ROW_REQ, '0, '0, 32'd1, 31'd1, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{ROW_REQ, '0, '0, 32'd2, 31'd0, 1'b1, 32'd0, 1'b0},
      '{ROW_CSR, lbrl_pkg::REG_LIMIT, 40'hFF_FFFF_FFFF, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_REQ, '0, '0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 32'd0, 1'b0},
      '{ROW_REQ, '0, '0, 32'd0, 31'd1, 1'b1, 32'd0, 1'b0},
      '{ROW_CSR, lbrl_pkg::REG_INTERVAL, 40'd1, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_CSR, lbrl_pkg::REG_LIMIT, 40'd1, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_REQ, '0, '0, 32'd0, 31'h7FFF_FFFF, 1'b1, 32'd0, 1'b0},
      '{ROW_REQ, '0, '0, 32'd0, 31'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFE, 1'b1},
      '{ROW_REQ, '0, '0, 32'd0, 31'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFD, 1'b1},
      '{ROW_REQ, '0, '0, 32'd0, 31'd1, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{ROW_CSR, REG_SPARE, 40'd0, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_REQ, '0, '0, 32'd0, 31'd1, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{ROW_REQ, '0, '0, 32'hFFFF_FFFF, 31'h2AAA_AAAA, 1'b0, '0, 1'b0},
      '{ROW_CSR, lbrl_pkg::REG_LIMIT, 40'hFF_FFFF_FFFF, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_REQ, '0, '0, 32'h8000_0000, 31'h5555_5555, 1'b0, '0, 1'b0},
      '{ROW_CSR, lbrl_pkg::REG_INTERVAL, 40'hFF_FFFF_FFFF, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_REQ, '0, '0, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, '0, 1'b0},
      '{ROW_REQ, '0, '0, 32'hAAAA_AAAA, 31'h2AAA_AAAA, 1'b0, '0, 1'b0},
      '{ROW_CSR, lbrl_pkg::REG_INTERVAL, 40'd0, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_REQ, '0, '0, 32'hAAAA_AAAA, 31'h5555_5555, 1'b1, 32'd0, 1'b0}
   };

   leaky_bucket_rate_limiter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_now_ms  (req_now_ms),
      .req_size    (req_size),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_wait_ms (rsp_wait_ms),
      .rsp_delayed (rsp_delayed),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #1 clock = ~clock;

   function automatic void bucket_config(input logic [lbrl_pkg::CSR_INDEX_W-1:0] index,
                                         input logic [lbrl_pkg::CSR_DATA_W-1:0] data);
      if (index == lbrl_pkg::REG_INTERVAL) begin
         interval_cfg = data[lbrl_pkg::INTERVAL_W-1:0];
      end else if (index == lbrl_pkg::REG_LIMIT) begin
         limit_cfg = data[lbrl_pkg::LIMIT_W-1:0];
      end else begin
         return;
      end
      bucket_level = '0;
      drain_mark_ms = '0;
      drain_rate = (interval_cfg == '0) ? '0
                 : limit_cfg / lbrl_pkg::LIMIT_W'(interval_cfg);
   endfunction

   function automatic grant_type bucket_step(input logic [lbrl_pkg::NOW_W-1:0] now_ms,
                                             input logic [lbrl_pkg::SIZE_W-1:0] size);
      grant_type                       grant;
      logic [lbrl_pkg::NOW_W-1:0]      elapsed;
      logic [lbrl_pkg::PROD_W-1:0]     drained;
      logic [lbrl_pkg::LEVEL_W-1:0]    quotient;
      logic [lbrl_pkg::LEVEL_W:0]      filled;
      grant = '0;
      if (size == '0 || interval_cfg == '0) begin
         return grant;
      end
      elapsed = now_ms - drain_mark_ms;
      if (elapsed >= {1'b0, interval_cfg}) begin
         if (drain_rate != '0) begin
            drained = lbrl_pkg::PROD_W'(elapsed) * lbrl_pkg::PROD_W'(drain_rate);
            bucket_level = (drained >= lbrl_pkg::PROD_W'(bucket_level)) ? '0
                         : bucket_level - drained[lbrl_pkg::LEVEL_W-1:0];
         end
         drain_mark_ms = now_ms;
      end
      if (bucket_level > lbrl_pkg::LEVEL_W'(limit_cfg)) begin
         grant.delayed = 1'b1;
         if (drain_rate == '0) begin
            grant.wait_ms = lbrl_pkg::WAIT_MAX;
         end else begin
            quotient = (bucket_level - lbrl_pkg::LEVEL_W'(limit_cfg))
                     / lbrl_pkg::LEVEL_W'(drain_rate);
            grant.wait_ms = (quotient > lbrl_pkg::LEVEL_W'(lbrl_pkg::WAIT_MAX))
                          ? lbrl_pkg::WAIT_MAX : quotient[lbrl_pkg::WAIT_W-1:0];
         end
      end
      filled = {1'b0, bucket_level}
             + {{(lbrl_pkg::LEVEL_W + 1 - lbrl_pkg::SIZE_W){1'b0}}, size};
      bucket_level = filled[lbrl_pkg::LEVEL_W] ? lbrl_pkg::LEVEL_MAX
                                               : filled[lbrl_pkg::LEVEL_W-1:0];
      return grant;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Called at a falling edge; returns at a falling edge with req_valid still high.
   task automatic send_grant_request(input logic [lbrl_pkg::NOW_W-1:0] now_ms,
                                     input logic [lbrl_pkg::SIZE_W-1:0] size,
                                     input logic typed, input grant_type typed_grant);
      grant_type predicted;
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_now_ms <= now_ms;
      req_size   <= size;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      predicted = bucket_step(now_ms, size);
      expected_grants.push_back(typed ? typed_grant : predicted);
   endtask

   task automatic write_register(input logic [lbrl_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [lbrl_pkg::CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (expected_grants.size() != 0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      bucket_config(index, data);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_gap_pct);
   end

   always @(posedge clock) begin : check_grants
      grant_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_grants.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat wait_ms=%h delayed=%b",
                                    rsp_wait_ms, rsp_delayed));
         end else begin
            want = expected_grants.pop_front();
            if (rsp_wait_ms !== want.wait_ms) begin
               flag_mismatch($sformatf("wait_ms got %h expected %h",
                                       rsp_wait_ms, want.wait_ms));
            end
            if (rsp_delayed !== want.delayed) begin
               flag_mismatch($sformatf("delayed got %b expected %b",
                                       rsp_delayed, want.delayed));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      int                              sent;
      int                              burst;
      int                              pick;
      logic [lbrl_pkg::INTERVAL_W-1:0] interval_pick;
      logic [lbrl_pkg::LIMIT_W-1:0]    limit_pick;
      logic [lbrl_pkg::NOW_W-1:0]      clock_ms;
      logic [lbrl_pkg::SIZE_W-1:0]     size_pick;
      logic [lbrl_pkg::SIZE_W-1:0]     size_cap;
      sent = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            write_register(directed_plan[i].index, directed_plan[i].data);
         end else begin
            send_grant_request(directed_plan[i].now_ms, directed_plan[i].size,
                               directed_plan[i].typed,
                               grant_type'{directed_plan[i].wait_ms,
                                           directed_plan[i].delayed});
         end
      end

      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: interval_pick = '0;
            1: interval_pick = 31'h7FFF_FFFF;
            2: interval_pick = 31'd1;
            3, 4, 5: interval_pick = lbrl_pkg::INTERVAL_W'($urandom_range(1, 16));
            6, 7, 8: interval_pick = lbrl_pkg::INTERVAL_W'($urandom_range(1, 2000));
            default: interval_pick = lbrl_pkg::INTERVAL_W'($urandom);
         endcase
         case ($urandom_range(0, 9))
            0: limit_pick = '0;
            1: limit_pick = 40'hFF_FFFF_FFFF;
            2: limit_pick = lbrl_pkg::LIMIT_W'({$urandom, $urandom});
            3: limit_pick = lbrl_pkg::LIMIT_W'($urandom_range(0, 100));
            default: limit_pick = lbrl_pkg::LIMIT_W'($urandom_range(0, 1000000));
         endcase
         pick = $urandom_range(0, 2);
         if ($urandom_range(0, 7) == 0) begin
            write_register(lbrl_pkg::CSR_INDEX_W'($urandom_range(2, 255)),
                           lbrl_pkg::CSR_DATA_W'({$urandom, $urandom}));
         end
         if (pick != 1) begin
            write_register(lbrl_pkg::REG_INTERVAL, {9'($urandom), interval_pick});
         end
         if (pick != 0) begin
            write_register(lbrl_pkg::REG_LIMIT, limit_pick);
         end
         size_cap = (limit_cfg == '0) ? lbrl_pkg::SIZE_W'(1000) :
                    (limit_cfg > 40'h7FFF_FFFF) ? 31'h7FFF_FFFF
                                                : limit_cfg[lbrl_pkg::SIZE_W-1:0];
         clock_ms = '0;
         burst = $urandom_range(20, 70);
         for (int n = 0; n < burst && sent < RANDOM_ITEMS; n++) begin
            if (sent < RANDOM_ITEMS / 3) begin
               req_gap_pct = 6;
               rsp_gap_pct = 45;
            end else if (sent < 2 * RANDOM_ITEMS / 3) begin
               req_gap_pct = 45;
               rsp_gap_pct = 6;
            end else begin
               req_gap_pct = 0;
               rsp_gap_pct = 0;
            end
            if ($urandom_range(0, 9) == 0) begin
               send_grant_request($urandom, lbrl_pkg::SIZE_W'($urandom), 1'b0, '0);
            end else begin
               case ($urandom_range(0, 3))
                  0: ;
                  1: clock_ms += (interval_cfg > 1) ? $urandom_range(0, interval_cfg - 1) : 0;
                  default: clock_ms += {1'b0, interval_cfg} + $urandom_range(0, interval_cfg);
               endcase
               case ($urandom_range(0, 19))
                  0: size_pick = '0;
                  1: size_pick = lbrl_pkg::SIZE_W'($urandom);
                  default: size_pick = lbrl_pkg::SIZE_W'($urandom_range(1, size_cap));
               endcase
               send_grant_request(clock_ms, size_pick, 1'b0, '0);
            end
            sent++;
         end
      end

      req_valid <= 1'b0;
      while (expected_grants.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
